// ===== sv/tcp_option_parser_macros.svh =====
// Assertion helpers for the TCP option parser.
`ifndef TCP_OPTION_PARSER_MACROS_SVH
`define TCP_OPTION_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// Checked only outside reset.
`define TOP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TOP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TOP_ASSERT(lbl, prop, msg)
`define TOP_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== sv/tcpop_pkg.sv =====
`default_nettype none

package tcpop_pkg;

  // Option kind bytes on the wire.
  localparam logic [7:0] OPT_END   = 8'd0;
  localparam logic [7:0] OPT_NOP   = 8'd1;
  localparam logic [7:0] OPT_MSS   = 8'd2;
  localparam logic [7:0] OPT_SCALE = 8'd3;
  localparam logic [7:0] OPT_SACK  = 8'd4;
  localparam logic [7:0] OPT_TS    = 8'd8;

  // Total option lengths minus the kind byte.
  localparam logic [3:0] BODY_MSS   = 4'd3;
  localparam logic [3:0] BODY_SCALE = 4'd2;
  localparam logic [3:0] BODY_SACK  = 4'd1;
  localparam logic [3:0] BODY_TS    = 4'd9;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
  localparam logic [1:0] STATUS_TRUNC   = 2'd2;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_MSS   = 2'd1,
    KIND_SCALE = 2'd2,
    KIND_SACK  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] option_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic [15:0] mss_value;
    logic        mss_found;
    logic [7:0]  window_scale;
    logic        scale_found;
    logic        sack_permitted;
    logic [1:0]  status;
  } out_req_t;

endpackage

`default_nettype wire

// ===== sv/tcp_option_parser.sv =====
`default_nettype none
// Channel   Ports                           Request
// input     in_valid in_stall in_data       one options byte and its last flag
// output    out_valid out_stall out_data    one summary per options area
// config    cfg_wr_en cfg_wr_data           sack_supported
//
// One byte per cycle is sustained while the input is not stalled.
// The summary appears in the output register the cycle after the last byte.
// Input stalls only while a summary sits in the output register and is stalled.
// Reset clears the parse state and sets sack_supported.

`include "tcp_option_parser_macros.svh"

module tcp_option_parser
  import tcpop_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_req_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_req_t      out_data,
  input  wire logic     cfg_wr_en,
  input  wire logic     cfg_wr_data
);

  logic        sack_sup_r;
  logic [3:0]  bytes_left_r, bytes_left_nxt;
  kind_t       kind_r, kind_nxt;
  logic [15:0] mss_hold_r, mss_hold_nxt;
  logic        mss_seen_r, mss_seen_nxt;
  logic [7:0]  mss_pend_r, mss_pend_nxt;
  logic [7:0]  scale_hold_r, scale_hold_nxt;
  logic        scale_seen_r, scale_seen_nxt;
  logic        sack_seen_r, sack_seen_nxt;
  logic        stopped_r, stopped_nxt;
  logic        out_valid_r;
  out_req_t    out_data_r, summary;
  logic        in_accept;

  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    bytes_left_nxt = bytes_left_r;
    kind_nxt       = kind_r;
    mss_hold_nxt   = mss_hold_r;
    mss_seen_nxt   = mss_seen_r;
    mss_pend_nxt   = mss_pend_r;
    scale_hold_nxt = scale_hold_r;
    scale_seen_nxt = scale_seen_r;
    sack_seen_nxt  = sack_seen_r;
    stopped_nxt    = stopped_r;

    if (in_accept && !stopped_r) begin
      if (bytes_left_r == 4'd0) begin
        case (in_data.option_byte)
          OPT_END, OPT_NOP: begin
          end
          OPT_MSS: begin
            kind_nxt       = KIND_MSS;
            bytes_left_nxt = BODY_MSS;
          end
          OPT_SCALE: begin
            kind_nxt       = KIND_SCALE;
            bytes_left_nxt = BODY_SCALE;
          end
          OPT_SACK: begin
            kind_nxt       = KIND_SACK;
            bytes_left_nxt = BODY_SACK;
          end
          OPT_TS: begin
            kind_nxt       = KIND_OTHER;
            bytes_left_nxt = BODY_TS;
          end
          default: stopped_nxt = 1'b1;
        endcase
      end else begin
        case (kind_r)
          KIND_MSS: begin
            if (bytes_left_r == 4'd2) begin
              mss_pend_nxt = in_data.option_byte;
            end else if (bytes_left_r == 4'd1) begin
              mss_hold_nxt = {mss_pend_r, in_data.option_byte};
              mss_seen_nxt = 1'b1;
            end
          end
          KIND_SCALE: begin
            if (bytes_left_r == 4'd1) begin
              scale_hold_nxt = in_data.option_byte;
              scale_seen_nxt = 1'b1;
            end
          end
          KIND_SACK: begin
            if (bytes_left_r == 4'd1 && sack_sup_r) begin
              sack_seen_nxt = 1'b1;
            end
          end
          default: begin
          end
        endcase
        bytes_left_nxt = bytes_left_r - 4'd1;
      end
    end

    summary.mss_value      = mss_seen_nxt ? mss_hold_nxt : 16'd0;
    summary.mss_found      = mss_seen_nxt;
    summary.window_scale   = scale_seen_nxt ? scale_hold_nxt : 8'd0;
    summary.scale_found    = scale_seen_nxt;
    summary.sack_permitted = sack_seen_nxt;
    if (stopped_nxt) begin
      summary.status = STATUS_UNKNOWN;
    end else if (bytes_left_nxt != 4'd0) begin
      summary.status = STATUS_TRUNC;
    end else begin
      summary.status = STATUS_OK;
    end

    // The area ends here, so the next byte starts a fresh parse.
    if (in_accept && in_data.last_byte) begin
      bytes_left_nxt = 4'd0;
      kind_nxt       = KIND_OTHER;
      mss_hold_nxt   = 16'd0;
      mss_seen_nxt   = 1'b0;
      mss_pend_nxt   = 8'd0;
      scale_hold_nxt = 8'd0;
      scale_seen_nxt = 1'b0;
      sack_seen_nxt  = 1'b0;
      stopped_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sack_sup_r   <= 1'b1;
      bytes_left_r <= 4'd0;
      kind_r       <= KIND_OTHER;
      mss_hold_r   <= 16'd0;
      mss_seen_r   <= 1'b0;
      mss_pend_r   <= 8'd0;
      scale_hold_r <= 8'd0;
      scale_seen_r <= 1'b0;
      sack_seen_r  <= 1'b0;
      stopped_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        sack_sup_r <= cfg_wr_data;
      end
      bytes_left_r <= bytes_left_nxt;
      kind_r       <= kind_nxt;
      mss_hold_r   <= mss_hold_nxt;
      mss_seen_r   <= mss_seen_nxt;
      mss_pend_r   <= mss_pend_nxt;
      scale_hold_r <= scale_hold_nxt;
      scale_seen_r <= scale_seen_nxt;
      sack_seen_r  <= sack_seen_nxt;
      stopped_r    <= stopped_nxt;
      if (in_accept && in_data.last_byte) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_data.last_byte) begin
      out_data_r <= summary;
    end
  end

  `TOP_ASSERT(a_last_clears, in_accept && in_data.last_byte |=> bytes_left_r == 4'd0 && !stopped_r && !mss_seen_r && !scale_seen_r && !sack_seen_r, "parse state not cleared after last byte")
  `TOP_ASSERT(a_last_gives_result, in_accept && in_data.last_byte |=> out_valid_r, "no summary after last byte")
  `TOP_ASSERT(a_stop_no_body, bytes_left_r != 4'd0 |-> !stopped_r, "parse stopped inside an option body")
  `TOP_ASSERT(a_status_code, !out_valid_r || out_data_r.status == STATUS_OK || out_data_r.status == STATUS_UNKNOWN || out_data_r.status == STATUS_TRUNC, "invalid status code")

endmodule

`default_nettype wire

// ===== sim/tcp_option_parser_tb.sv =====
`default_nettype none

module tcp_option_parser_tb;
  import tcpop_pkg::*;

  localparam int QUIET_LIMIT = 600;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_req_t out_data;
  logic     cfg_wr_en = 1'b0;
  logic     cfg_wr_data = 1'b0;

  tcp_option_parser u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  in_req_t  pending_bytes[$];
  out_req_t expected_summaries[$];
  int       queued_count = 0;
  int       accepted_count = 0;
  int       error_count = 0;
  int       report_count = 0;
  int       quiet_cycles = 0;
  int       gap_left = 0;
  int       stall_left = 0;
  bit       idle_on = 1'b1;
  bit       drain_wait = 1'b0;

  // Shadow of the parser state.
  logic        sack_enabled = 1'b1;
  logic [3:0]  opt_remaining = '0;
  kind_t       opt_kind = KIND_OTHER;
  logic [15:0] mss_acc = '0;
  logic [7:0]  mss_high = '0;
  logic        mss_ok = 1'b0;
  logic [7:0]  scale_acc = '0;
  logic        scale_ok = 1'b0;
  logic        sack_ok = 1'b0;
  logic        halted = 1'b0;

  function automatic void parse_option_byte(in_req_t req);
    out_req_t summary;
    if (!halted) begin
      if (opt_remaining == 4'd0) begin
        case (req.option_byte)
          OPT_END, OPT_NOP: begin
          end
          OPT_MSS: begin
            opt_kind = KIND_MSS;
            opt_remaining = BODY_MSS;
          end
          OPT_SCALE: begin
            opt_kind = KIND_SCALE;
            opt_remaining = BODY_SCALE;
          end
          OPT_SACK: begin
            opt_kind = KIND_SACK;
            opt_remaining = BODY_SACK;
          end
          OPT_TS: begin
            opt_kind = KIND_OTHER;
            opt_remaining = BODY_TS;
          end
          default: halted = 1'b1;
        endcase
      end else begin
        case (opt_kind)
          KIND_MSS: begin
            if (opt_remaining == 4'd2) begin
              mss_high = req.option_byte;
            end else if (opt_remaining == 4'd1) begin
              mss_acc = {mss_high, req.option_byte};
              mss_ok = 1'b1;
            end
          end
          KIND_SCALE: begin
            if (opt_remaining == 4'd1) begin
              scale_acc = req.option_byte;
              scale_ok = 1'b1;
            end
          end
          KIND_SACK: begin
            if (opt_remaining == 4'd1 && sack_enabled) sack_ok = 1'b1;
          end
          default: begin
          end
        endcase
        opt_remaining = opt_remaining - 4'd1;
      end
    end
    if (req.last_byte) begin
      summary.mss_value      = mss_ok ? mss_acc : 16'd0;
      summary.mss_found      = mss_ok;
      summary.window_scale   = scale_ok ? scale_acc : 8'd0;
      summary.scale_found    = scale_ok;
      summary.sack_permitted = sack_ok;
      if (halted) summary.status = STATUS_UNKNOWN;
      else if (opt_remaining != 4'd0) summary.status = STATUS_TRUNC;
      else summary.status = STATUS_OK;
      expected_summaries.push_back(summary);
      opt_remaining = '0;
      opt_kind = KIND_OTHER;
      mss_acc = '0;
      mss_high = '0;
      mss_ok = 1'b0;
      scale_acc = '0;
      scale_ok = 1'b0;
      sack_ok = 1'b0;
      halted = 1'b0;
    end
  endfunction

  function automatic bit is_known_kind(logic [7:0] b);
    return b == OPT_END || b == OPT_NOP || b == OPT_MSS || b == OPT_SCALE ||
           b == OPT_SACK || b == OPT_TS;
  endfunction

  function automatic void push_area(logic [7:0] bytes[$]);
    in_req_t req;
    for (int i = 0; i < bytes.size(); i++) begin
      req.option_byte = bytes[i];
      req.last_byte = (i == bytes.size() - 1);
      pending_bytes.push_back(req);
      queued_count++;
    end
  endfunction

  // Length bytes are usually right, sometimes anything.
  function automatic logic [7:0] length_byte(logic [7:0] good);
    return ($urandom_range(0, 3) == 0) ? 8'($urandom) : good;
  endfunction

  // Builds one options area, mostly well-formed, and returns how many of its
  // bytes the parser actually looks at.
  function automatic int add_area();
    logic [7:0] area[$];
    logic [7:0] b;
    int n_opts;
    int stop_at;
    int cut;
    n_opts = $urandom_range(0, 6);
    stop_at = -1;
    for (int i = 0; i < n_opts && stop_at < 0; i++) begin
      case ($urandom_range(0, 15))
        0, 15: area.push_back(OPT_NOP);
        1: area.push_back(OPT_END);
        2, 3, 4: begin
          area.push_back(OPT_MSS);
          area.push_back(length_byte(8'd4));
          area.push_back(8'($urandom));
          area.push_back(8'($urandom));
        end
        5, 6, 7: begin
          area.push_back(OPT_SCALE);
          area.push_back(length_byte(8'd3));
          area.push_back(8'($urandom));
        end
        8, 9: begin
          area.push_back(OPT_SACK);
          area.push_back(length_byte(8'd2));
        end
        10, 11, 12: begin
          area.push_back(OPT_TS);
          area.push_back(length_byte(8'd10));
          for (int j = 0; j < 8; j++) area.push_back(8'($urandom));
        end
        13: begin
          do b = 8'($urandom); while (is_known_kind(b));
          stop_at = area.size();
          area.push_back(b);
        end
        default: begin
          b = 8'($urandom);
          if (!is_known_kind(b)) stop_at = area.size();
          area.push_back(b);
        end
      endcase
    end
    // The bytes after an unknown kind are ignored, so only a few follow it.
    if (stop_at >= 0) begin
      n_opts = $urandom_range(0, 3);
      for (int j = 0; j < n_opts; j++) area.push_back(8'($urandom));
    end
    if (area.size() == 0) area.push_back(8'($urandom_range(0, 4)));
    if (area.size() > 1 && $urandom_range(0, 4) == 0) begin
      cut = $urandom_range(1, area.size() - 1);
      while (area.size() > cut) void'(area.pop_back());
    end
    push_area(area);
    if (stop_at >= 0 && stop_at + 1 < area.size()) return stop_at + 1;
    return area.size();
  endfunction

  task automatic wait_drained();
    while (accepted_count != queued_count) @(posedge clk);
    while (expected_summaries.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_sack_cfg(logic value);
    wait_drained();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    sack_enabled = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 1'b0;
  endtask

  task automatic run_random(int target);
    int seen;
    seen = 0;
    while (seen < target) seen += add_area();
  endtask

  // Byte sender.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        parse_option_byte(in_data);
        accepted_count++;
        if (in_data.last_byte && idle_on && $urandom_range(0, 29) == 0) drain_wait = 1'b1;
      end
      if (!in_valid || !in_stall) begin
        if (drain_wait && expected_summaries.size() != 0) begin
          in_valid <= 1'b0;
        end else if (gap_left > 0) begin
          drain_wait = 1'b0;
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          drain_wait = 1'b0;
          in_data <= pending_bytes.pop_front();
          in_valid <= 1'b1;
          if (idle_on && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 12);
        end else begin
          drain_wait = 1'b0;
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Summary receiver and checker.
  always @(posedge clk) begin
    out_req_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_fire) begin
        if (expected_summaries.size() == 0) begin
          error_count++;
          if (report_count < 10) begin
            report_count++;
            $display("unexpected summary %p", out_data);
          end
        end else begin
          want = expected_summaries.pop_front();
          if (out_data.mss_value !== want.mss_value ||
              out_data.mss_found !== want.mss_found ||
              out_data.window_scale !== want.window_scale ||
              out_data.scale_found !== want.scale_found ||
              out_data.sack_permitted !== want.sack_permitted ||
              out_data.status !== want.status) begin
            error_count++;
            if (report_count < 10) begin
              report_count++;
              $display("summary mismatch: expected %p, got %p", want, out_data);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 11);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Ends a run in which nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_fire || out_fire) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[tcp_option_parser] ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] area[$];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Largest MSS.
    area = {OPT_MSS, 8'd4, 8'hFF, 8'hFF};
    push_area(area);
    // NOP, scale, SACK-permitted and a closing END.
    area = {OPT_NOP, OPT_SCALE, 8'd3, 8'h0E, OPT_SACK, 8'd2, OPT_END};
    push_area(area);
    // A repeated MSS overwrites the first one, then a scale option is cut off.
    area = {OPT_MSS, 8'd4, 8'hAB, 8'hCD, OPT_MSS, 8'd4, 8'h00, 8'h01, OPT_SCALE};
    push_area(area);
    // An unknown kind on the last byte itself.
    area = {8'hFF};
    push_area(area);
    // Scale of zero, then an unknown kind and bytes that must be ignored.
    area = {OPT_SCALE, 8'd3, 8'h00, 8'h07, OPT_MSS, 8'h22};
    push_area(area);
    // A timestamp cut short, with the largest scale before it.
    area = {OPT_SCALE, 8'hFF, 8'hFF, OPT_TS, 8'd10, 8'h11};
    push_area(area);

    write_sack_cfg(1'b0);
    run_random(600);
    write_sack_cfg(1'b1);
    idle_on = 1'b0;
    run_random(500);
    write_sack_cfg(1'b0);
    idle_on = 1'b1;
    run_random(400);
    write_sack_cfg(1'b1);
    idle_on = 1'b0;
    run_random(450);

    wait_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("[tcp_option_parser] OK");
    end else begin
      $display("[tcp_option_parser] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/tcpop_pkg.sv
sv/tcp_option_parser.sv
sim/tcp_option_parser_tb.sv
